FILE: sv/lsqf_pkg.sv
package lsqf_pkg;

   localparam logic [1:0] MODE_TICK  = 2'd0;
   localparam logic [1:0] MODE_LOAD  = 2'd1;
   localparam logic [1:0] MODE_STORE = 2'd2;
   localparam logic [1:0] MODE_NOP   = 2'd3;

   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_LOAD  = 2'd1;
   localparam logic [1:0] KIND_STORE = 2'd2;

   typedef struct packed {
      logic [1:0]         mode;
      logic [4:0]         seq;
      logic signed [31:0] base;
      logic signed [31:0] offset;
      logic signed [31:0] store_data;
      logic [4:0]         rob_tail;
   } req_type;

   typedef struct packed {
      logic [1:0]         issued_kind;
      logic [4:0]         issued_seq;
      logic signed [31:0] issued_addr;
      logic signed [31:0] issued_value;
      logic               was_forwarded;
      logic               needs_memory;
      logic               writeback;
      logic               dispatch_dropped;
      logic               queue_full;
   } rsp_type;

   typedef struct packed {
      logic        is_store;
      logic [4:0]  seq;
      logic [31:0] addr;
      logic [31:0] value;
      logic        fwd;
   } entry_type;

   typedef struct packed {
      logic not_younger;
      logic addr_hit;
   } cmp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_EV,
      ST_INSERT_LAST,
      ST_TICK_RD,
      ST_TICK_EV,
      ST_DONE
   } state_type;

endpackage

FILE: sv/lsqf_ram.sv
module lsqf_ram import lsqf_pkg::*; #(
   parameter int DEPTH = 8,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  entry_type     wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output entry_type     rd_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/lsqf_cmp.sv
module lsqf_cmp import lsqf_pkg::*; #(
   parameter int ROB_DEPTH = 32
) (
   input  logic [4:0]  entry_seq,
   input  logic [4:0]  item_seq,
   input  logic [4:0]  rob_tail,
   input  logic [31:0] entry_addr,
   input  logic [31:0] item_addr,
   output cmp_type     cmp_res
);

   localparam int KW = $clog2(ROB_DEPTH + 32);

   function automatic logic [KW-1:0] order_key(input logic [4:0] s, input logic [4:0] tail);
      logic [KW-1:0] k;
      k = KW'(s);
      if (s < tail) begin
         k = k + KW'(ROB_DEPTH);
      end
      return k;
   endfunction

   logic [KW-1:0] entry_key;
   logic [KW-1:0] item_key;

   assign entry_key = order_key(entry_seq, rob_tail);
   assign item_key  = order_key(item_seq, rob_tail);

   assign cmp_res.not_younger = (entry_key <= item_key);
   assign cmp_res.addr_hit    = (entry_addr == item_addr);

endmodule

FILE: sv/load_store_queue_forwarding_unit.sv
// Load/store queue with store-to-load forwarding, kept in program order.
// Input channel req_*: one transfer carries a tick (issue the oldest entry
// or end a stall), a load or store dispatch, or a no-op. Result channel rsp_*:
// exactly one transfer per accepted item, in order, giving the issued entry
// (if any), the drop flag of a dispatch into a full queue and the full status.
// Entries sit in a circular buffer memory with one write and one registered
// read port; a single compare unit checks order key and address of one entry
// at a time.
// Steps per item, from acceptance to result offered:
//   dispatch        each held entry is read, then evaluated; entries younger
//                   than the item ripple one slot up through the memory port
//   tick that pops  one memory read of the oldest entry
//   other items     straight to the result
// req_ready returns in the same cycle as the result is offered.
// req_ready is high only while the sequencer is idle; the next item may be
// taken while the last result still waits. If the receiver stalls, the
// following item finishes and holds until the result register frees up.
// Reset (synchronous, active high) empties the queue and clears the stall
// tick; memory contents are left as they are and are never read unwritten.
module load_store_queue_forwarding_unit import lsqf_pkg::*; #(
   parameter int QUEUE_DEPTH = 8,
   parameter int ROB_DEPTH   = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [AW-1:0] off);
      logic [AW:0] s;
      s = {1'b0, h} + {1'b0, off};
      if (s >= (AW+1)'(QUEUE_DEPTH)) begin
         s = s - (AW+1)'(QUEUE_DEPTH);
      end
      return s[AW-1:0];
   endfunction

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] head_ff, head_in;
   logic busy_ff, busy_in;
   logic [CW-1:0] j_ff, j_in;
   logic ins_ff, ins_in;
   logic stop_ff, stop_in;
   logic lst_seen_ff, lst_seen_in;
   logic lst_hit_ff, lst_hit_in;
   logic [31:0] lst_val_ff, lst_val_in;
   entry_type carry_ff, carry_in;
   req_type item_ff, item_in;
   logic [31:0] addr_ff, addr_in;
   rsp_type pend_ff, pend_in;
   rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic wr_en;
   logic [AW-1:0] wr_addr;
   entry_type wr_data;
   logic rd_en;
   logic [AW-1:0] rd_addr;
   entry_type rd_data;
   cmp_type cmp_res;

   logic full;
   logic req_dispatch;
   logic item_store;
   logic active;
   entry_type new_entry;
   entry_type e_mod;

   lsqf_ram #(.DEPTH(QUEUE_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lsqf_cmp #(.ROB_DEPTH(ROB_DEPTH)) u_cmp (
      .entry_seq  (rd_data.seq),
      .item_seq   (item_ff.seq),
      .rob_tail   (item_ff.rob_tail),
      .entry_addr (rd_data.addr),
      .item_addr  (addr_ff),
      .cmp_res    (cmp_res)
   );

   assign full         = (count_ff == CW'(QUEUE_DEPTH));
   assign req_dispatch = (req_data.mode == MODE_LOAD) || (req_data.mode == MODE_STORE);
   assign item_store   = (item_ff.mode == MODE_STORE);
   assign active       = ins_ff || !cmp_res.not_younger;

   always_comb begin
      new_entry.is_store = item_store;
      new_entry.seq      = item_ff.seq;
      new_entry.addr     = addr_ff;
      new_entry.fwd      = !item_store && lst_seen_ff && lst_hit_ff;
      if (item_store) begin
         new_entry.value = item_ff.store_data;
      end else if (lst_seen_ff && lst_hit_ff) begin
         new_entry.value = lst_val_ff;
      end else begin
         new_entry.value = '0;
      end
   end

   always_comb begin
      e_mod = rd_data;
      if (item_store && !stop_ff && cmp_res.addr_hit && !rd_data.is_store) begin
         e_mod.value = item_ff.store_data;
         e_mod.fwd   = 1'b1;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.mode == MODE_TICK) begin
                  state_in = (!busy_ff && (count_ff != '0)) ? ST_TICK_RD : ST_DONE;
               end else if (req_dispatch && !full) begin
                  state_in = ST_SCAN_RD;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCAN_RD:     state_in = (j_ff == count_ff) ? ST_INSERT_LAST : ST_SCAN_EV;
         ST_SCAN_EV:     state_in = ST_SCAN_RD;
         ST_INSERT_LAST: state_in = ST_DONE;
         ST_TICK_RD:     state_in = ST_TICK_EV;
         ST_TICK_EV:     state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default:        state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      wr_en        = 1'b0;
      wr_addr      = phys(head_ff, j_ff[AW-1:0]);
      wr_data      = ins_ff ? carry_ff : new_entry;
      rd_en        = 1'b0;
      rd_addr      = phys(head_ff, j_ff[AW-1:0]);
      count_in     = count_ff;
      head_in      = head_ff;
      busy_in      = busy_ff;
      j_in         = j_ff;
      ins_in       = ins_ff;
      stop_in      = stop_ff;
      lst_seen_in  = lst_seen_ff;
      lst_hit_in   = lst_hit_ff;
      lst_val_in   = lst_val_ff;
      carry_in     = carry_ff;
      item_in      = item_ff;
      addr_in      = addr_ff;
      pend_in      = pend_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in     = req_data;
               addr_in     = 32'(req_data.base + req_data.offset);
               pend_in     = '0;
               j_in        = '0;
               ins_in      = 1'b0;
               stop_in     = 1'b0;
               lst_seen_in = 1'b0;
               if ((req_data.mode == MODE_TICK) && busy_ff) begin
                  busy_in = 1'b0;
               end
               if (req_dispatch && full) begin
                  pend_in.dispatch_dropped = 1'b1;
               end
            end
         end
         ST_SCAN_RD: begin
            rd_en = (j_ff != count_ff);
         end
         ST_SCAN_EV: begin
            j_in = j_ff + 1'b1;
            if (!active) begin
               if (rd_data.is_store) begin
                  lst_seen_in = 1'b1;
                  lst_hit_in  = cmp_res.addr_hit;
                  lst_val_in  = rd_data.value;
               end
            end else begin
               wr_en    = 1'b1;
               carry_in = e_mod;
               ins_in   = 1'b1;
               if (item_store && cmp_res.addr_hit && rd_data.is_store) begin
                  stop_in = 1'b1;
               end
            end
         end
         ST_INSERT_LAST: begin
            wr_en    = 1'b1;
            count_in = count_ff + 1'b1;
         end
         ST_TICK_RD: begin
            rd_en   = 1'b1;
            rd_addr = head_ff;
         end
         ST_TICK_EV: begin
            pend_in.issued_kind   = rd_data.is_store ? KIND_STORE : KIND_LOAD;
            pend_in.issued_seq    = rd_data.seq;
            pend_in.issued_addr   = rd_data.addr;
            pend_in.issued_value  = (rd_data.is_store || rd_data.fwd) ? rd_data.value : '0;
            pend_in.was_forwarded = !rd_data.is_store && rd_data.fwd;
            pend_in.needs_memory  = !rd_data.is_store && !rd_data.fwd;
            pend_in.writeback     = 1'b1;
            busy_in  = !rd_data.is_store && !rd_data.fwd;
            head_in  = (head_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
            count_in = count_ff - 1'b1;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in            = pend_ff;
               rsp_in.queue_full = full;
               rsp_valid_in      = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff        <= j_in;
      ins_ff      <= ins_in;
      stop_ff     <= stop_in;
      lst_seen_ff <= lst_seen_in;
      lst_hit_ff  <= lst_hit_in;
      lst_val_ff  <= lst_val_in;
      carry_ff    <= carry_in;
      item_ff     <= item_in;
      addr_ff     <= addr_in;
      pend_ff     <= pend_in;
      rsp_ff      <= rsp_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INSERT_LAST) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("insert did not grow the queue");

   a_memory_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.needs_memory |->
         (rsp_ff.issued_kind == KIND_LOAD) && (rsp_ff.issued_value == '0) && rsp_ff.writeback)
      else $error("memory read flagged on a non-load result");

   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.dispatch_dropped |-> rsp_ff.queue_full && !rsp_ff.writeback)
      else $error("dropped dispatch without full queue");

   a_stall_tick: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TICK_EV) && !rd_data.is_store && !rd_data.fwd |=> busy_ff)
      else $error("unforwarded load did not stall the queue");

endmodule

FILE: dv/lsq_forward_checker.sv
module lsq_forward_checker import lsqf_pkg::*; #(
   parameter int QUEUE_DEPTH = 8,
   parameter int ROB_DEPTH   = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   entry_type   slots [QUEUE_DEPTH];
   int          held;
   bit          stall_tick;
   rsp_type     issue_q [$];
   int          mismatch_total = 0;
   int          pending_total  = 0;

   assign fail_count    = mismatch_total;
   assign pending_count = pending_total;

   function automatic int unsigned order_key(logic [4:0] s, logic [4:0] tail);
      return s + ((s < tail) ? ROB_DEPTH : 0);
   endfunction

   function automatic int field_diff(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   task automatic dispatch_entry(input req_type r);
      logic [31:0] addr;
      logic [31:0] value;
      int unsigned key;
      int          pos;
      int          j;
      bit          is_store;
      bit          fwd;
      is_store = (r.mode == MODE_STORE);
      addr     = r.base + r.offset;
      key      = order_key(r.seq, r.rob_tail);
      value    = is_store ? r.store_data : 32'd0;
      fwd      = 1'b0;
      pos      = 0;
      while (pos < held && order_key(slots[pos].seq, r.rob_tail) <= key)
         pos++;
      if (!is_store) begin
         for (j = pos - 1; j >= 0; j--) begin
            if (slots[j].is_store) begin
               if (slots[j].addr == addr) begin
                  value = slots[j].value;
                  fwd   = 1'b1;
               end
               break;
            end
         end
      end else begin
         for (j = pos; j < held; j++) begin
            if (slots[j].addr == addr) begin
               if (slots[j].is_store)
                  break;
               slots[j].value = r.store_data;
               slots[j].fwd   = 1'b1;
            end
         end
      end
      for (j = held; j > pos; j--)
         slots[j] = slots[j - 1];
      slots[pos].is_store = is_store;
      slots[pos].seq      = r.seq;
      slots[pos].addr     = addr;
      slots[pos].value    = value;
      slots[pos].fwd      = fwd;
      held++;
   endtask

   task automatic predict_result(input req_type r, output rsp_type o);
      int j;
      o = '0;
      if (r.mode == MODE_TICK) begin
         if (stall_tick) begin
            stall_tick = 1'b0;
         end else if (held > 0) begin
            o.issued_kind = slots[0].is_store ? KIND_STORE : KIND_LOAD;
            o.issued_seq  = slots[0].seq;
            o.issued_addr = slots[0].addr;
            if (slots[0].is_store) begin
               o.issued_value = slots[0].value;
            end else if (slots[0].fwd) begin
               o.issued_value  = slots[0].value;
               o.was_forwarded = 1'b1;
            end else begin
               o.needs_memory = 1'b1;
               stall_tick     = 1'b1;
            end
            o.writeback = 1'b1;
            for (j = 1; j < held; j++)
               slots[j - 1] = slots[j];
            held--;
         end
      end else if (r.mode == MODE_LOAD || r.mode == MODE_STORE) begin
         if (held >= QUEUE_DEPTH)
            o.dispatch_dropped = 1'b1;
         else
            dispatch_entry(r);
      end
      o.queue_full = (held >= QUEUE_DEPTH);
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      rsp_type got;
      int      errs;
      if (reset) begin
         held       = 0;
         stall_tick = 1'b0;
         issue_q.delete();
      end else begin
         errs = 0;
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (issue_q.size() == 0) begin
               $error("result transfer with no result outstanding");
               errs = 1;
            end else begin
               want = issue_q.pop_front();
               errs += field_diff("issued_kind", want.issued_kind, got.issued_kind);
               errs += field_diff("issued_seq", want.issued_seq, got.issued_seq);
               errs += field_diff("issued_addr", want.issued_addr, got.issued_addr);
               errs += field_diff("issued_value", want.issued_value, got.issued_value);
               errs += field_diff("was_forwarded", want.was_forwarded, got.was_forwarded);
               errs += field_diff("needs_memory", want.needs_memory, got.needs_memory);
               errs += field_diff("writeback", want.writeback, got.writeback);
               errs += field_diff("dispatch_dropped", want.dispatch_dropped,
                                  got.dispatch_dropped);
               errs += field_diff("queue_full", want.queue_full, got.queue_full);
            end
         end
         if (req_valid && req_ready) begin
            predict_result(req_data, want);
            issue_q.push_back(want);
         end
         mismatch_total <= mismatch_total + errs;
      end
      pending_total <= issue_q.size();
   end

endmodule

FILE: dv/tb_top.sv
module tb_top import lsqf_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 1500;
   localparam int CYCLE_LIMIT  = 400000;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int      fail_count;
   int      pending_count;
   int      cycle_count = 0;
   bit      send_steady = 1'b0;
   bit      take_steady = 1'b0;

   load_store_queue_forwarding_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   lsq_forward_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic req_type make_req(logic [1:0] mode, logic [4:0] seq,
                                        logic [31:0] base, logic [31:0] offset,
                                        logic [31:0] data, logic [4:0] tail);
      req_type r;
      r.mode       = mode;
      r.seq        = seq;
      r.base       = base;
      r.offset     = offset;
      r.store_data = data;
      r.rob_tail   = tail;
      return r;
   endfunction

   // hold valid and payload until the transfer
   task automatic send_req(input req_type item);
      int gap;
      gap = send_steady ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   initial begin : receiver
      int stall;
      int taken;
      taken = 0;
      forever begin
         if (taken % 80 == 0)
            take_steady = ($urandom_range(0, 3) == 0);
         stall = take_steady ? 0 : $urandom_range(0, 14);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   initial begin : stimulus
      logic [31:0] addr_pool [4];
      logic [31:0] addr;
      logic [31:0] base;
      logic [4:0]  tail;
      logic [1:0]  mode;
      int          bias;
      int          roll;
      int          n;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: empty tick, forwarding both ways, wrap, full queue, stall
      send_req(make_req(MODE_TICK, 5'd0, 32'h0, 32'h0, 32'h0, 5'd0));
      send_req(make_req(MODE_STORE, 5'd2, 32'h8000_0000, 32'h8000_1000, 32'h7fff_ffff, 5'd0));
      send_req(make_req(MODE_LOAD, 5'd3, 32'h0000_1000, 32'h0, 32'h0, 5'd0));
      send_req(make_req(MODE_LOAD, 5'd1, 32'h0000_0800, 32'h0000_0800, 32'h0, 5'd0));
      send_req(make_req(MODE_STORE, 5'd4, 32'h0000_2000, 32'h0, 32'h1234_5678, 5'd0));
      send_req(make_req(MODE_LOAD, 5'd5, 32'h0000_1000, 32'h0000_1000, 32'hffff_ffff, 5'd0));
      send_req(make_req(MODE_STORE, 5'd0, 32'h0000_1000, 32'h0, 32'h8000_0000, 5'd0));
      send_req(make_req(MODE_LOAD, 5'd6, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0, 5'd0));
      send_req(make_req(MODE_STORE, 5'd31, 32'hffff_ffff, 32'h0, 32'hffff_ffff, 5'd0));
      send_req(make_req(MODE_LOAD, 5'd7, 32'h0000_1000, 32'h0, 32'h0, 5'd0));
      send_req(make_req(MODE_NOP, 5'd31, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 5'd31));
      repeat (11)
         send_req(make_req(MODE_TICK, 5'd0, 32'h0, 32'h0, 32'h0, 5'd0));
      send_req(make_req(MODE_STORE, 5'd1, 32'h0000_1000, 32'h0, 32'hcafe_f00d, 5'd30));
      send_req(make_req(MODE_LOAD, 5'd31, 32'h0000_1000, 32'h0, 32'h0, 5'd30));
      send_req(make_req(MODE_LOAD, 5'd2, 32'h0000_1000, 32'h0, 32'h0, 5'd30));

      tail = 5'd30;
      bias = 50;
      foreach (addr_pool[i])
         addr_pool[i] = $urandom;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 150 == 0)
            send_steady = ($urandom_range(0, 3) == 0);
         if (n % 100 == 0)
            bias = 30 + 20 * $urandom_range(0, 2);
         if (n % 200 == 0)
            foreach (addr_pool[i])
               addr_pool[i] = $urandom;
         if ($urandom_range(0, 49) == 0)
            tail = 5'($urandom);
         roll = $urandom_range(0, 99);
         if (roll < 2)
            mode = MODE_NOP;
         else if (roll < 2 + bias)
            mode = $urandom_range(0, 1) ? MODE_STORE : MODE_LOAD;
         else
            mode = MODE_TICK;
         addr = ($urandom_range(0, 4) == 0) ? $urandom : addr_pool[$urandom_range(0, 3)];
         base = $urandom;
         send_req(make_req(mode, 5'($urandom), base, addr - base, $urandom,
                           ($urandom_range(0, 9) == 0) ? 5'($urandom) : tail));
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
